// ----- rtl/core/bplru_pkg.sv -----
// Shared constants and types for the bit-PLRU cache tag tracker.
package bplru_pkg;

  localparam int unsigned SETS_DEF     = 16;
  localparam int unsigned WAYS_DEF     = 4;
  localparam int unsigned TAG_BITS_DEF = 10;

  localparam int unsigned SET_IDX_W = 4;
  localparam int unsigned IN_TAG_W  = 10;
  localparam int unsigned WAY_OUT_W = 2;
  localparam int unsigned CNT_W     = 32;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

endpackage

// ----- rtl/core/bplru_if.sv -----
// Valid/ready channel interfaces for lookup requests and lookup results.
interface bplru_in_if import bplru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SET_IDX_W-1:0] set_index;
  logic [IN_TAG_W-1:0]  tag;

  modport source (output valid, output set_index, output tag, input ready);
  modport sink   (input valid, input set_index, input tag, output ready);
endinterface

interface bplru_out_if import bplru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     access_count;

  modport source (output valid, output hit, output way, output hit_count,
                  output access_count, input ready);
  modport sink   (input valid, input hit, input way, input hit_count,
                  input access_count, output ready);
endinterface

// ----- rtl/core/bit_plru_cache_tracker_unit.sv -----
// Tag store of a set-associative cache with bit-pseudo-LRU replacement.
// Each accepted word (set index, tag) returns one result word: hit flag, the
// way hit or filled, and wrapping hit and access counts. Tags, valid bits and
// used bits of a set share one row of a synchronous single-port-read memory.
// A lookup first reads the row into a register, then compares, picks the way
// and writes the row back; a new word is taken only once the last has left the
// LOOKUP state. The result sits in an output register, and a new word is taken
// while it waits. After reset a clearing pass writes every row before the
// first word is accepted.
module bit_plru_cache_tracker_unit import bplru_pkg::*; #(
  parameter int unsigned SETS     = SETS_DEF,
  parameter int unsigned WAYS     = WAYS_DEF,
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bplru_in_if.sink    in_ch,
  bplru_out_if.source out_ch
);

  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned IDX_N  = 2 ** SET_IDX_W;

  typedef struct packed {
    logic [WAYS-1:0]                used;
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0][TAG_BITS-1:0]  tags;
  } row_t;

  row_t row_mem [SETS];
  row_t rd_row_r;

  state_t state_r, state_nxt;
  logic [SET_W-1:0]    clr_cnt_r;
  logic [SET_W-1:0]    set_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [SET_W-1:0]    set_tab [IDX_N];

  logic [CNT_W-1:0] hits_r, hits_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;

  logic            in_fire;
  logic            lk_go;
  logic            hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] fill_way;
  logic [WAY_W-1:0] sel;
  logic [WAYS-1:0] sel_oh;
  logic [WAYS-1:0] used_set;
  row_t            wb_row;
  logic            wr_en;
  logic [SET_W-1:0] wr_addr;
  row_t            wr_row;

  for (genvar i = 0; i < IDX_N; i++) begin : g_set_tab
    localparam int unsigned SET_MOD = i % SETS;
    assign set_tab[i] = SET_W'(SET_MOD);
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign lk_go       = (state_r == ST_LOOKUP) && (!out_valid_r || out_ch.ready);

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row_r.valid[w] && (rd_row_r.tags[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    fill_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!rd_row_r.used[w]) begin
        fill_way = WAY_W'(w);
      end
    end
    sel    = hit ? hit_way : fill_way;
    sel_oh = WAYS'(1) << sel;

    used_set = rd_row_r.used | sel_oh;
    wb_row   = rd_row_r;
    wb_row.used  = (&used_set) ? sel_oh : used_set;
    wb_row.valid = rd_row_r.valid | sel_oh;
    if (!hit) begin
      wb_row.tags[sel] = tag_r;
    end

    hits_nxt = hits_r + CNT_W'(hit);
    acc_nxt  = acc_r + CNT_W'(1);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = set_r;
    wr_row  = wb_row;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_row  = '0;
    end else if (lk_go) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SET_W'(SETS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (lk_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_row;
    end
    if (in_fire) begin
      rd_row_r <= row_mem[set_tab[in_ch.set_index]];
      set_r    <= set_tab[in_ch.set_index];
      tag_r    <= TAG_BITS'(in_ch.tag);
    end
    if (lk_go) begin
      out_hit_r <= hit;
      out_way_r <= WAY_OUT_W'(sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      hits_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
      if (lk_go) begin
        hits_r      <= hits_nxt;
        acc_r       <= acc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.way          = out_way_r;
  assign out_ch.hit_count    = hits_r;
  assign out_ch.access_count = acc_r;

  a_fire_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOOKUP))
    else $error("accepted word did not start a lookup");

  a_go_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    lk_go |=> (out_valid_r && (acc_r == $past(acc_r) + CNT_W'(1))))
    else $error("result not loaded or access count not advanced");

  a_hit_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    lk_go |=> (hits_r == $past(hits_r) + CNT_W'($past(hit))))
    else $error("hit count out of step with hit flag");

  a_used_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    lk_go |-> !(&wb_row.used))
    else $error("write-back leaves every used bit of the set high");

  a_no_fire_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !wr_en || (wr_addr == clr_cnt_r))
    else $error("clearing pass wrote the wrong row");

endmodule

// ----- tb/sv/bit_plru_cache_tracker_unit_test.sv -----
// Self-checking testbench for the bit-PLRU cache tag tracker: lookup stimulus, prediction, checks.
module bit_plru_cache_tracker_unit_test import bplru_pkg::*;;

  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned RANDOM_WORDS = 1450;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned POOL_SIZE   = 6;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     access_count;
  } lookup_result_t;

  class lookup_scoreboard;
    bit [IN_TAG_W-1:0] line_tags [SETS_DEF][WAYS_DEF];
    bit [WAYS_DEF-1:0] line_valid [SETS_DEF];
    bit [WAYS_DEF-1:0] used_bits [SETS_DEF];
    bit [CNT_W-1:0]    hits_seen;
    bit [CNT_W-1:0]    lookups_seen;
    lookup_result_t    expected_lookups [$];
    int                mismatches;

    function void note_word(bit [SET_IDX_W-1:0] set_idx, bit [IN_TAG_W-1:0] tag);
      int unsigned    s;
      int unsigned    sel;
      bit             found;
      lookup_result_t r;
      s = set_idx % SETS_DEF;
      found = 1'b0;
      sel = 0;
      lookups_seen = lookups_seen + 1;
      for (int unsigned w = 0; w < WAYS_DEF; w++) begin
        if (!found && line_valid[s][w] && line_tags[s][w] == tag) begin
          found = 1'b1;
          sel = w;
        end
      end
      if (found) begin
        hits_seen = hits_seen + 1;
      end else begin
        for (int unsigned w = 0; w < WAYS_DEF; w++) begin
          if (!used_bits[s][w]) sel = w;
        end
        line_tags[s][sel] = tag;
        line_valid[s][sel] = 1'b1;
      end
      used_bits[s][sel] = 1'b1;
      if (&used_bits[s]) begin
        used_bits[s] = '0;
        used_bits[s][sel] = 1'b1;
      end
      r.hit = found;
      r.way = sel[WAY_OUT_W-1:0];
      r.hit_count = hits_seen;
      r.access_count = lookups_seen;
      expected_lookups = {expected_lookups, r};
    endfunction

    function void flag(string what, lookup_result_t exp_r, lookup_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (%s): expected hit=%0d way=%0d hits=%0d accesses=%0d",
                 what, exp_r.hit, exp_r.way, exp_r.hit_count, exp_r.access_count);
        $display("               actual   hit=%0d way=%0d hits=%0d accesses=%0d",
                 got.hit, got.way, got.hit_count, got.access_count);
      end
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp_r;
      if (expected_lookups.size() == 0) begin
        flag("result with nothing pending", '0, got);
      end else begin
        exp_r = expected_lookups.pop_front();
        if (got.hit !== exp_r.hit || got.way !== exp_r.way ||
            got.hit_count !== exp_r.hit_count ||
            got.access_count !== exp_r.access_count) begin
          flag("field", exp_r, got);
        end
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    function void close_out();
      mismatches += expected_lookups.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   steady = 1'b0;
  int unsigned stall_cycles = 0;

  bplru_in_if  in_ch ();
  bplru_out_if out_ch ();

  lookup_scoreboard sb = new();

  bit_plru_cache_tracker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sink side: check results, stall at random
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.hit, out_ch.way, out_ch.hit_count, out_ch.access_count});
    end
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_lookup(input bit [SET_IDX_W-1:0] set_idx, input bit [IN_TAG_W-1:0] tag);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      in_ch.set_index <= SET_IDX_W'($urandom);
      in_ch.tag <= IN_TAG_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.set_index <= set_idx;
    in_ch.tag <= tag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(set_idx, tag);
  endtask

  initial begin
    bit [IN_TAG_W-1:0]  tag_pool [POOL_SIZE];
    bit [SET_IDX_W-1:0] set_idx;
    bit [IN_TAG_W-1:0]  tag;

    in_ch.valid <= 1'b0;
    in_ch.set_index <= '0;
    in_ch.tag <= '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // fill, hit, evict and wrap-around of the used bits at both set extremes
    send_lookup(0, 0);
    send_lookup(0, 0);
    send_lookup(15, 1023);
    send_lookup(15, 1023);
    send_lookup(0, 1);
    send_lookup(0, 2);
    send_lookup(0, 3);
    send_lookup(0, 4);
    send_lookup(0, 0);
    send_lookup(0, 1);
    send_lookup(0, 2);
    send_lookup(0, 3);
    send_lookup(15, 0);
    send_lookup(15, 512);
    send_lookup(15, 341);
    send_lookup(15, 682);
    send_lookup(15, 1023);
    send_lookup(7, 5);
    send_lookup(8, 5);
    send_lookup(7, 5);

    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 200 == 0) begin
        foreach (tag_pool[k]) tag_pool[k] = IN_TAG_W'($urandom);
      end
      steady = (i >= 500 && i < 800);
      set_idx = ($urandom_range(0, 1) == 0) ? SET_IDX_W'($urandom_range(0, 3))
                                            : SET_IDX_W'($urandom);
      if ($urandom_range(0, 99) < 70) begin
        tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        tag = IN_TAG_W'($urandom);
      end
      send_lookup(set_idx, tag);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
